### hdl/buhr_pkg.sv
// Shared types and constants for the bounded undo/redo history unit.
// Used by buhr_ctrl, buhr_store and bounded_undo_redo_history_unit.
// No dependencies.
`default_nettype none

package buhr_pkg;

  // Field widths fixed by the interface
  localparam int REQ_W    = 2;
  localparam int HANDLE_W = 32;
  localparam int LIMIT_W  = 8;
  localparam int COUNT_W  = 8;

  // Defaults
  localparam int HISTORY_DEPTH_DEF = 128;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd100;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_UNDO   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REDO   = 2'd2;

  // Source of the shown handle in a result
  typedef enum logic [1:0] {
    SHOW_NONE,
    SHOW_NEW,
    SHOW_MEM
  } show_sel_t;

  // Result flags handed from the control logic to the result register
  typedef struct packed {
    show_sel_t            sel;
    logic                 undo_ready;
    logic                 redo_ready;
    logic                 ignored;
    logic                 dropped;
    logic [COUNT_W-1:0]   entry_count;
  } res_t;

endpackage

`default_nettype wire

### hdl/bounded_undo_redo_history_unit.sv
// Top level of the bounded undo/redo history unit.
// Depends on buhr_pkg, buhr_ctrl and buhr_store.
//
//  channel   | handshake              | payload
//  ----------+------------------------+--------------------------------------------
//  request   | start / busy           | in_req_type, in_handle
//  result    | out_valid (strobe)     | out_shown_handle, out_undo_ready,
//            |                        | out_redo_ready, out_entry_count,
//            |                        | out_ignored, out_dropped_oldest
//  config    | cfg_valid / cfg_ready  | cfg_history_limit
//
// One request per cycle. The result strobe is registered from acceptance and comes in the
// cycle after it: the pointer update and the store read port are both registered.
// busy is high only while reset is held; cfg_ready is always high.
// Synchronous active-low reset clears the pointers and sets the limit to 100;
// the handle store is not cleared. Results are never held off.
`default_nettype none

module bounded_undo_redo_history_unit #(
  parameter int HISTORY_DEPTH = buhr_pkg::HISTORY_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // request
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [buhr_pkg::REQ_W-1:0]    in_req_type,
  input  wire logic [buhr_pkg::HANDLE_W-1:0] in_handle,
  // result
  output logic                               out_valid,
  output logic      [buhr_pkg::HANDLE_W-1:0] out_shown_handle,
  output logic                               out_undo_ready,
  output logic                               out_redo_ready,
  output logic      [buhr_pkg::COUNT_W-1:0]  out_entry_count,
  output logic                               out_ignored,
  output logic                               out_dropped_oldest,
  // config
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [buhr_pkg::LIMIT_W-1:0]  cfg_history_limit
);

  localparam int AW = $clog2(HISTORY_DEPTH);

  logic                          acc;
  logic                          wr_en;
  logic [AW-1:0]                 wr_addr;
  logic [AW-1:0]                 rd_addr;
  logic [buhr_pkg::HANDLE_W-1:0] rd_data_r;
  buhr_pkg::res_t                res_nxt;
  buhr_pkg::res_t                res_r;
  logic [buhr_pkg::HANDLE_W-1:0] handle_r;
  logic                          out_valid_r;

  assign busy      = ~rst_n;
  assign cfg_ready = 1'b1;
  assign acc       = start & ~busy;

  buhr_ctrl #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_valid & cfg_ready),
    .cfg_data(cfg_history_limit),
    .acc     (acc),
    .req     (in_req_type),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .rd_addr (rd_addr),
    .res_nxt (res_nxt)
  );

  buhr_store #(
    .HISTORY_DEPTH(HISTORY_DEPTH)
  ) u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (in_handle),
    .rd_addr  (rd_addr),
    .rd_data_r(rd_data_r)
  );

  // Result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= acc;
    end
  end

  // Result payload, new handle kept for the insert bypass
  always_ff @(posedge clk) begin
    if (acc) begin
      res_r    <= res_nxt;
      handle_r <= in_handle;
    end
  end

  // Shown handle select
  always_comb begin
    case (res_r.sel)
      buhr_pkg::SHOW_NEW: out_shown_handle = handle_r;
      buhr_pkg::SHOW_MEM: out_shown_handle = rd_data_r;
      default:            out_shown_handle = '0;
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_undo_ready     = res_r.undo_ready;
  assign out_redo_ready     = res_r.redo_ready;
  assign out_entry_count    = res_r.entry_count;
  assign out_ignored        = res_r.ignored;
  assign out_dropped_oldest = res_r.dropped;

endmodule

`default_nettype wire

### hdl/buhr_store.sv
// Handle store of the history ring: one write port, one registered read port.
// Depends on buhr_pkg for the handle width.
`default_nettype none

module buhr_store #(
  parameter int HISTORY_DEPTH = buhr_pkg::HISTORY_DEPTH_DEF,
  localparam int AW = $clog2(HISTORY_DEPTH)
) (
  input  wire logic                          clk,
  input  wire logic                          wr_en,
  input  wire logic [AW-1:0]                 wr_addr,
  input  wire logic [buhr_pkg::HANDLE_W-1:0] wr_data,
  input  wire logic [AW-1:0]                 rd_addr,
  output logic      [buhr_pkg::HANDLE_W-1:0] rd_data_r
);

  logic [buhr_pkg::HANDLE_W-1:0] mem [HISTORY_DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### hdl/buhr_ctrl.sv
// Ring pointer state, limit register and next-state logic of the history.
// Depends on buhr_pkg for request codes, widths and the result struct.
`default_nettype none

module buhr_ctrl #(
  parameter int HISTORY_DEPTH = buhr_pkg::HISTORY_DEPTH_DEF,
  localparam int AW = $clog2(HISTORY_DEPTH)
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // config write
  input  wire logic                          cfg_we,
  input  wire logic [buhr_pkg::LIMIT_W-1:0]  cfg_data,
  // accepted request
  input  wire logic                          acc,
  input  wire logic [buhr_pkg::REQ_W-1:0]    req,
  // store access
  output logic                               wr_en,
  output logic      [AW-1:0]                 wr_addr,
  output logic      [AW-1:0]                 rd_addr,
  // result of this request
  output buhr_pkg::res_t                     res_nxt
);

  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam int LW = (CW > buhr_pkg::LIMIT_W) ? CW : buhr_pkg::LIMIT_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);
  localparam logic [AW:0]   DEPTH_S = (AW+1)'(HISTORY_DEPTH);

  logic [buhr_pkg::LIMIT_W-1:0] limit_r;
  logic [AW-1:0] oldest_r, oldest_nxt;
  logic [CW-1:0] held_r, held_nxt;
  logic [CW-1:0] cursor_r, cursor_nxt;

  logic [CW-1:0] lim;
  logic [LW-1:0] limit_ext;
  logic          full;
  logic [AW-1:0] wr_off;
  logic [CW-1:0] held1;
  logic [AW-1:0] old1;
  logic [CW-1:0] trim;
  logic [CW-1:0] rd_off;
  logic [LW-1:0] held_ext;
  logic          ignored;
  logic          dropped;

  // ring slot add with wrap, sum stays below twice the depth
  function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
    logic [AW:0] t;
    t = s - DEPTH_S;
    return (s >= DEPTH_S) ? t[AW-1:0] : s[AW-1:0];
  endfunction

  // Effective limit: zero acts as one, clamp at depth
  always_comb begin
    limit_ext = LW'(limit_r);
    if (limit_ext == '0) begin
      lim = CW'(1);
    end else if (limit_ext > LW'(HISTORY_DEPTH)) begin
      lim = DEPTH_C;
    end else begin
      lim = limit_ext[CW-1:0];
    end
  end

  // Next-state logic
  always_comb begin
    full       = (cursor_r >= DEPTH_C);
    wr_off     = full ? '0 : cursor_r[AW-1:0];
    wr_addr    = wrap({1'b0, oldest_r} + {1'b0, wr_off});
    held1      = full ? DEPTH_C : cursor_r + CW'(1);
    old1       = full ? wrap({1'b0, oldest_r} + (AW+1)'(1)) : oldest_r;
    trim       = held1 - lim;
    oldest_nxt = oldest_r;
    held_nxt   = held_r;
    cursor_nxt = cursor_r;
    ignored    = 1'b0;
    dropped    = 1'b0;
    wr_en      = 1'b0;
    rd_off     = cursor_r - CW'(1);

    case (req)
      buhr_pkg::REQ_INSERT: begin
        wr_en   = acc;
        dropped = full;
        if (held1 > lim) begin
          oldest_nxt = wrap({1'b0, old1} + {1'b0, trim[AW-1:0]});
          held_nxt   = lim;
          dropped    = 1'b1;
        end else begin
          oldest_nxt = old1;
          held_nxt   = held1;
        end
        cursor_nxt = held_nxt;
      end
      buhr_pkg::REQ_UNDO: begin
        if (cursor_r <= CW'(1)) begin
          ignored = 1'b1;
        end else begin
          cursor_nxt = cursor_r - CW'(1);
          rd_off     = cursor_r - CW'(2);
        end
      end
      buhr_pkg::REQ_REDO: begin
        if (cursor_r >= held_r) begin
          ignored = 1'b1;
        end else begin
          cursor_nxt = cursor_r + CW'(1);
          rd_off     = cursor_r;
        end
      end
      default: begin
        ignored = 1'b1;
      end
    endcase

    // current entry for undo, redo and rejected requests
    rd_addr = wrap({1'b0, oldest_r} + {1'b0, rd_off[AW-1:0]});

    held_ext               = LW'(held_nxt);
    res_nxt.entry_count    = held_ext[buhr_pkg::COUNT_W-1:0];
    res_nxt.undo_ready     = (cursor_nxt > CW'(1));
    res_nxt.redo_ready     = (cursor_nxt < held_nxt);
    res_nxt.ignored        = ignored;
    res_nxt.dropped        = dropped;
    if (req == buhr_pkg::REQ_INSERT) begin
      res_nxt.sel = buhr_pkg::SHOW_NEW;
    end else if (cursor_nxt == '0) begin
      res_nxt.sel = buhr_pkg::SHOW_NONE;
    end else begin
      res_nxt.sel = buhr_pkg::SHOW_MEM;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= buhr_pkg::LIMIT_RESET;
      oldest_r <= '0;
      held_r   <= '0;
      cursor_r <= '0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_data;
      end
      if (acc) begin
        oldest_r <= oldest_nxt;
        held_r   <= held_nxt;
        cursor_r <= cursor_nxt;
      end
    end
  end

endmodule

`default_nettype wire

### tb/sv/buhr_history_checker.sv
// Checker for the bounded undo/redo history unit: watches the request, result and
// config channels, predicts each result and compares it field by field.
// Depends on buhr_pkg.
`timescale 1ns / 100ps

module buhr_history_checker
  import buhr_pkg::*;
#(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  logic [REQ_W-1:0]    in_req_type,
  input  logic [HANDLE_W-1:0] in_handle,
  input  logic                out_valid,
  input  logic [HANDLE_W-1:0] out_shown_handle,
  input  logic                out_undo_ready,
  input  logic                out_redo_ready,
  input  logic [COUNT_W-1:0]  out_entry_count,
  input  logic                out_ignored,
  input  logic                out_dropped_oldest,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [LIMIT_W-1:0]  cfg_history_limit,
  output int                  fail_count,
  output int                  pending
);

  // What the history looks like after one request
  typedef struct packed {
    logic [HANDLE_W-1:0] shown_handle;
    logic                undo_ready;
    logic                redo_ready;
    logic [COUNT_W-1:0]  entry_count;
    logic                ignored;
    logic                dropped_oldest;
  } hist_view_t;

  // Shadow copy of the ring and its pointers
  logic [HANDLE_W-1:0] handle_ring [HISTORY_DEPTH];
  int unsigned         first_slot;
  int unsigned         kept;
  int unsigned         cur;
  logic [LIMIT_W-1:0]  limit_reg;

  hist_view_t views_due[$];

  // Apply one request to the shadow history and return the view it produces
  function automatic hist_view_t apply_request(logic [REQ_W-1:0] req,
                                               logic [HANDLE_W-1:0] hnd);
    hist_view_t  v;
    int unsigned lim;
    v = '0;
    lim = (limit_reg == 0) ? 1 :
          ((limit_reg > HISTORY_DEPTH) ? HISTORY_DEPTH : limit_reg);
    if (req == REQ_INSERT) begin
      // everything above the cursor is discarded
      kept = cur;
      if (kept >= HISTORY_DEPTH) begin
        // full ring: overwrite the oldest slot
        handle_ring[first_slot] = hnd;
        first_slot = (first_slot + 1) % HISTORY_DEPTH;
        kept = HISTORY_DEPTH;
        v.dropped_oldest = 1'b1;
      end else begin
        handle_ring[(first_slot + kept) % HISTORY_DEPTH] = hnd;
        kept++;
      end
      if (kept > lim) begin
        first_slot = (first_slot + kept - lim) % HISTORY_DEPTH;
        kept = lim;
        v.dropped_oldest = 1'b1;
      end
      cur = kept;
    end else if (req == REQ_UNDO) begin
      if (cur <= 1) v.ignored = 1'b1;
      else cur--;
    end else if (req == REQ_REDO) begin
      if (cur >= kept) v.ignored = 1'b1;
      else cur++;
    end else begin
      v.ignored = 1'b1;
    end
    v.shown_handle = (cur > 0) ? handle_ring[(first_slot + cur - 1) % HISTORY_DEPTH] : '0;
    v.undo_ready   = (cur > 1);
    v.redo_ready   = (cur < kept);
    v.entry_count  = kept[COUNT_W-1:0];
    return v;
  endfunction

  task automatic check_field(string name, logic [HANDLE_W-1:0] want,
                             logic [HANDLE_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Results first, then config, then the newly accepted request
  always @(posedge clk) begin
    hist_view_t want;
    if (!rst_n) begin
      first_slot = 0;
      kept       = 0;
      cur        = 0;
      limit_reg  = LIMIT_RESET;
      views_due.delete();
    end else begin
      if (out_valid) begin
        if (views_due.size() == 0) begin
          $display("%0t: result with none expected, expected nothing, actual %0h", $time,
                   out_shown_handle);
          fail_count++;
        end else begin
          want = views_due.pop_front();
          check_field("shown_handle", want.shown_handle, out_shown_handle);
          check_field("undo_ready", want.undo_ready, out_undo_ready);
          check_field("redo_ready", want.redo_ready, out_redo_ready);
          check_field("entry_count", want.entry_count, out_entry_count);
          check_field("ignored", want.ignored, out_ignored);
          check_field("dropped_oldest", want.dropped_oldest, out_dropped_oldest);
        end
      end
      if (cfg_valid && cfg_ready) limit_reg = cfg_history_limit;
      if (start && !busy) views_due = {views_due, apply_request(in_req_type, in_handle)};
    end
    pending = views_due.size();
  end

endmodule

### tb/sv/bounded_undo_redo_history_unit_test.sv
// Testbench top for the bounded undo/redo history unit: clock, reset, stimulus and verdict.
// Depends on buhr_pkg, bounded_undo_redo_history_unit and buhr_history_checker.
`timescale 1ns / 100ps

module bounded_undo_redo_history_unit_test;
  import buhr_pkg::*;

  localparam int                 WATCHDOG_CYCLES = 400;
  localparam logic [REQ_W-1:0]   REQ_SPARE       = 2'd3;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [REQ_W-1:0]    in_req_type = '0;
  logic [HANDLE_W-1:0] in_handle = '0;
  logic                out_valid;
  logic [HANDLE_W-1:0] out_shown_handle;
  logic                out_undo_ready;
  logic                out_redo_ready;
  logic [COUNT_W-1:0]  out_entry_count;
  logic                out_ignored;
  logic                out_dropped_oldest;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [LIMIT_W-1:0]  cfg_history_limit = '0;
  int                  fail_count;
  int                  pending;
  int                  quiet_cycles = 0;
  bit                  no_gaps = 1'b0;

  bounded_undo_redo_history_unit #(.HISTORY_DEPTH(HISTORY_DEPTH_DEF)) u_top (
    .clk, .rst_n, .start, .busy, .in_req_type, .in_handle,
    .out_valid, .out_shown_handle, .out_undo_ready, .out_redo_ready,
    .out_entry_count, .out_ignored, .out_dropped_oldest,
    .cfg_valid, .cfg_ready, .cfg_history_limit
  );

  buhr_history_checker #(.HISTORY_DEPTH(HISTORY_DEPTH_DEF)) u_checker (
    .clk, .rst_n, .start, .busy, .in_req_type, .in_handle,
    .out_valid, .out_shown_handle, .out_undo_ready, .out_redo_ready,
    .out_entry_count, .out_ignored, .out_dropped_oldest,
    .cfg_valid, .cfg_ready, .cfg_history_limit,
    .fail_count, .pending
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Watchdog: cycles in which no transaction of any kind happens
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_CYCLES) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Handles lean toward the all-zero and all-one extremes now and then
  function automatic logic [HANDLE_W-1:0] pick_handle();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // One request transaction after a random gap; start stays high for the next one
  task automatic issue_request(input logic [REQ_W-1:0] req, input logic [HANDLE_W-1:0] hnd);
    int gap;
    if ($urandom_range(0, 99) < 5) no_gaps = ~no_gaps;
    gap = no_gaps ? 0 : $urandom_range(0, 19);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start       <= 1'b1;
    in_req_type <= req;
    in_handle   <= hnd;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Write the limit once the unit has drained
  task automatic set_limit(input logic [LIMIT_W-1:0] value);
    @(negedge clk) start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (2) @(negedge clk);
    cfg_history_limit <= value;
    cfg_valid         <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // Random requests; occasional undo runs so later inserts discard redo entries
  task automatic run_phase(input logic [LIMIT_W-1:0] value, input int insert_pct,
                           input int items);
    int sent;
    int pick;
    int run_len;
    sent = 0;
    set_limit(value);
    while (sent < items) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        run_len = $urandom_range(1, 12);
        repeat (run_len) issue_request(REQ_UNDO, pick_handle());
        sent += run_len;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < insert_pct) issue_request(REQ_INSERT, pick_handle());
        else if (pick < insert_pct + (100 - insert_pct) / 2) issue_request(REQ_UNDO, pick_handle());
        else if (pick < 96) issue_request(REQ_REDO, pick_handle());
        else issue_request(REQ_SPARE, pick_handle());
        sent++;
      end
    end
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty history, extremes, undo at bottom, redo at top, discard on insert
    issue_request(REQ_UNDO, '0);
    issue_request(REQ_REDO, '1);
    issue_request(REQ_SPARE, '1);
    issue_request(REQ_INSERT, '0);
    issue_request(REQ_INSERT, '1);
    issue_request(REQ_INSERT, 32'h8000_0001);
    issue_request(REQ_UNDO, '0);
    issue_request(REQ_UNDO, '0);
    issue_request(REQ_UNDO, '0);
    issue_request(REQ_REDO, '0);
    issue_request(REQ_REDO, '0);
    issue_request(REQ_REDO, '0);
    issue_request(REQ_UNDO, '0);
    issue_request(REQ_INSERT, 32'h5A5A_A5A5);
    issue_request(REQ_REDO, '0);
    issue_request(REQ_SPARE, '0);

    // Insert-heavy phase with the limit above depth, then mix
    run_phase(8'd255, 100, 135);
    run_phase(8'd255, 60, 100);
    // Lowered limit: trimming happens at the next insert
    run_phase(8'd3, 50, 125);
    run_phase(8'd0, 50, 125);
    run_phase(8'd1, 50, 125);
    run_phase(8'd128, 80, 125);
    run_phase(8'd129, 80, 125);
    run_phase(8'd2, 50, 125);
    run_phase(8'd100, 60, 125);
    run_phase(8'($urandom_range(0, 255)), 55, 125);
    run_phase(8'($urandom_range(0, 255)), 50, 125);

    // Drain and let the last result land
    @(negedge clk) start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (fail_count == 0 && pending == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
